@@ rtl/core/eight_channel_cv_byte_framer_macros.svh @@
// Assertion macros shared by the framer modules.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef EIGHT_CHANNEL_CV_BYTE_FRAMER_MACROS_SVH
`define EIGHT_CHANNEL_CV_BYTE_FRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ECF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// Next-cycle implication.
`define ECF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`else

`define ECF_ASSERT_NOW(label, ante, cons)
`define ECF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/ecf_pkg.sv @@
package ecf_pkg;

	// Clamped, offset level held for one channel.
	localparam int CV_W = 12;
	localparam int CV_MIN = -2048;
	localparam int CV_MAX = 2047;

	localparam int NUM_CH = 8;
	localparam int CH_W = 3;

	typedef logic [CV_W-1:0] cv_t;
	typedef logic [CH_W-1:0] chan_t;
	typedef logic [1:0] slot_t;

	// Slot codes within one channel's three bytes.
	localparam slot_t SLOT_LO = 2'd0;
	localparam slot_t SLOT_MID = 2'd1;
	localparam slot_t SLOT_HI = 2'd2;
	localparam slot_t SLOT_SPARE = 2'd3;

	// Marker bits of the code byte.
	localparam logic [7:0] LEAD_MARK = 8'h80;
	localparam logic [7:0] GROUP_UPPER = 8'h40;
	localparam logic [7:0] GROUP_LOWER = 8'h20;

	// Position inside the 24-slot frame.
	typedef struct packed {
		slot_t slot;
		chan_t chan;
	} frame_pos_t;

endpackage

@@ rtl/core/ecf_ifs.sv @@
// Sample request channel: eight channel samples per request.
interface ecf_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] chan0_sample;
	logic signed [SAMPLE_WIDTH-1:0] chan1_sample;
	logic signed [SAMPLE_WIDTH-1:0] chan2_sample;
	logic signed [SAMPLE_WIDTH-1:0] chan3_sample;
	logic signed [SAMPLE_WIDTH-1:0] chan4_sample;
	logic signed [SAMPLE_WIDTH-1:0] chan5_sample;
	logic signed [SAMPLE_WIDTH-1:0] chan6_sample;
	logic signed [SAMPLE_WIDTH-1:0] chan7_sample;

	modport source (
		output valid, chan0_sample, chan1_sample, chan2_sample, chan3_sample,
		output chan4_sample, chan5_sample, chan6_sample, chan7_sample,
		input ready
	);
	modport sink (
		input valid, chan0_sample, chan1_sample, chan2_sample, chan3_sample,
		input chan4_sample, chan5_sample, chan6_sample, chan7_sample,
		output ready
	);
endinterface

// Code byte channel: one byte per request.
interface ecf_code_if;
	logic valid;
	logic ready;
	logic [7:0] code_byte;

	modport source (output valid, code_byte, input ready);
	modport sink (input valid, code_byte, output ready);
endinterface

@@ rtl/core/ecf_clamp_lane.sv @@
module ecf_clamp_lane #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic signed [SAMPLE_WIDTH-1:0] sample,
	output ecf_pkg::cv_t level
);
	import ecf_pkg::*;

	localparam logic signed [SAMPLE_WIDTH-1:0] CvHi = SAMPLE_WIDTH'(CV_MAX);
	localparam logic signed [SAMPLE_WIDTH-1:0] CvLo = SAMPLE_WIDTH'(CV_MIN);

	// Saturate to the 12-bit range, then offset by half scale.
	// Adding 2048 to an in-range value only flips its top bit.
	always_comb begin
		if (sample > CvHi) begin
			level = {CV_W{1'b1}};
		end else if (sample < CvLo) begin
			level = '0;
		end else begin
			level = {~sample[CV_W-1], sample[CV_W-2:0]};
		end
	end

endmodule

@@ rtl/core/ecf_merge.sv @@
`include "eight_channel_cv_byte_framer_macros.svh"

module ecf_merge (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input ecf_pkg::cv_t levels [ecf_pkg::NUM_CH],
	output logic [7:0] code,
	output ecf_pkg::frame_pos_t pos
);
	import ecf_pkg::*;

	frame_pos_t pos_q;
	frame_pos_t pos_next;
	cv_t held_q;
	cv_t held_next;
	logic [7:0] group;

	assign pos = pos_q;

	// The first slot of a channel latches that channel's lane result.
	assign held_next = (pos_q.slot == SLOT_LO) ? levels[pos_q.chan] : held_q;
	assign group = pos_q.chan[CH_W-1] ? GROUP_UPPER : GROUP_LOWER;

	// Encode the byte for the current slot.
	always_comb begin
		case (pos_q.slot)
			SLOT_LO: code = LEAD_MARK | {3'b000, held_next[4:0]};
			SLOT_MID: code = {3'b000, held_q[9:5]};
			default: code = {6'b0, held_q[11:10]} | group | {4'b0, pos_q.chan[1:0], 2'b00};
		endcase
	end

	// Step through three slots per channel, wrapping after channel 7.
	always_comb begin
		if (pos_q.slot inside {SLOT_HI, SLOT_SPARE}) begin
			pos_next.slot = SLOT_LO;
			pos_next.chan = pos_q.chan + 1'b1;
		end else begin
			pos_next.slot = pos_q.slot + 1'b1;
			pos_next.chan = pos_q.chan;
		end
	end

	// Frame state advances once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			held_q <= '0;
		end else if (advance) begin
			pos_q <= pos_next;
			held_q <= held_next;
		end
	end

	`ECF_ASSERT_NEXT(a_chan_wrap, advance && pos_q.slot == SLOT_HI,
		pos_q.slot == SLOT_LO && pos_q.chan == $past(pos_q.chan) + 3'd1)
	`ECF_ASSERT_NEXT(a_held_kept, advance && pos_q.slot != SLOT_LO, $stable(held_q))
	`ECF_ASSERT_NOW(a_lead_mark, pos_q.slot == SLOT_LO, code[7] && !code[6] && !code[5])

endmodule

@@ rtl/core/eight_channel_cv_byte_framer.sv @@
// Eight-channel CV byte framer. Each accepted request carries one sample for
// each of eight channels and yields exactly one code byte. A frame of 24 bytes
// walks channels 0 to 7 with three bytes each: on a channel's first byte its
// sample is saturated to -2048..2047 and offset to an unsigned 12-bit level,
// which the three bytes then carry as a marked low part, a middle part, and a
// top part with the channel group and number. Samples of other channels in
// that request are ignored. The block takes one request per clock cycle unless
// the output stalls; a byte appears on the output in the cycle after its
// request is accepted and is held in a single output register, so a request
// is taken whenever that register is empty or being drained in the same cycle.
`include "eight_channel_cv_byte_framer_macros.svh"

module eight_channel_cv_byte_framer #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	ecf_sample_if.sink samples,
	ecf_code_if.source codes
);
	import ecf_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] lane_in [NUM_CH];
	cv_t levels [NUM_CH];
	logic accept;
	logic [7:0] code;
	frame_pos_t pos;
	logic out_valid_q;
	logic [7:0] code_q;

	assign lane_in[0] = samples.chan0_sample;
	assign lane_in[1] = samples.chan1_sample;
	assign lane_in[2] = samples.chan2_sample;
	assign lane_in[3] = samples.chan3_sample;
	assign lane_in[4] = samples.chan4_sample;
	assign lane_in[5] = samples.chan5_sample;
	assign lane_in[6] = samples.chan6_sample;
	assign lane_in[7] = samples.chan7_sample;

	// One clamp lane per channel.
	for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
		ecf_clamp_lane #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_lane (
			.sample(lane_in[i]),
			.level(levels[i])
		);
	end

	// Handshake: take a request whenever the output register can move on.
	assign samples.ready = !out_valid_q || codes.ready;
	assign accept = samples.valid && samples.ready;

	ecf_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.advance(accept),
		.levels(levels),
		.code(code),
		.pos(pos)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (codes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= code;
		end
	end

	assign codes.valid = out_valid_q;
	assign codes.code_byte = code_q;

	`ECF_ASSERT_NEXT(a_byte_follows, accept, codes.valid && codes.code_byte == $past(code))
	`ECF_ASSERT_NEXT(a_pos_holds, !accept, pos == $past(pos))

endmodule
